[sv/tsb64_pkg.sv]
// ----------------------------------------------------------------------------
// Token segment base64url decoder package
// Result record, code constants and the symbol lookup shared by the decoder.
// ----------------------------------------------------------------------------
package tsb64_pkg;

   localparam logic       KIND_DATA      = 1'b0;
   localparam logic       KIND_STATUS    = 1'b1;

   localparam logic [1:0] SEG_HEADER     = 2'd0;
   localparam logic [1:0] SEG_PAYLOAD    = 2'd1;
   localparam logic [1:0] SEG_SIGNATURE  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_DOT1 = 2'd1;
   localparam logic [1:0] STATUS_NO_DOT2 = 2'd2;

   localparam logic [7:0] CHAR_DOT       = 8'h2E;

   // bit 6 set marks a character outside the alphabet
   localparam logic [6:0] SYM_NONE       = 7'd64;

   typedef struct packed {
      logic       item_kind;
      logic       segment_tag;
      logic [7:0] data_byte;
      logic [1:0] status_code;
      logic       end_mark;
   } result_type;

   function automatic logic [6:0] symbol_value(input logic [7:0] c);
      logic [6:0] v;
      v = SYM_NONE;
      if (c inside {[8'h41:8'h5A]}) begin
         v = 7'(c - 8'h41);
      end else if (c inside {[8'h61:8'h7A]}) begin
         v = 7'(c - 8'h61 + 8'd26);
      end else if (c inside {[8'h30:8'h39]}) begin
         v = 7'(c - 8'h30 + 8'd52);
      end else if (c inside {8'h2B, 8'h2D}) begin
         v = 7'd62;
      end else if (c inside {8'h2F, 8'h5F}) begin
         v = 7'd63;
      end
      return v;
   endfunction

endpackage

[sv/token_segment_base64url_decoder.sv]
// ----------------------------------------------------------------------------
// Token segment base64url decoder
// Splits a dotted token into header, payload and signature, decodes the first
// two segments as base64url and reports an end-of-token status.
// ----------------------------------------------------------------------------
// Results are registered in the result queue before they reach rsp_.
// Characters are taken one per cycle while req_stall is low; each result is a
// separate rsp_ transfer, and a character can yield both a byte and a status.
// A four-entry result queue sets the slack; req_stall rises at three entries.
// Reset empties the queue and returns to the header segment with no bits held.
module token_segment_base64url_decoder
   import tsb64_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_item_kind,
   output logic       rsp_segment_tag,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_status_code,
   output logic       rsp_end_mark
);

   logic [1:0]  seg_ff,  seg_in;
   logic [2:0]  pend_ff, pend_in;
   logic [5:0]  acc_ff,  acc_in;

   result_type  queue_ff [4];
   logic [1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [2:0]  count_ff,  count_in;

   logic        req_take, rsp_take;
   logic [6:0]  sym;
   logic        is_dot, active, sym_ok;
   logic [2:0]  p_clamp;
   logic [11:0] combined, mask;
   logic [3:0]  np_raw;
   logic [2:0]  np;
   logic        emit;
   logic [7:0]  dec_byte;
   logic [1:0]  seg_next;
   logic [1:0]  status;
   result_type  res_data, res_stat, res0, res1;
   logic [1:0]  push_n;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign req_stall = count_ff > 3'd2;

   always_comb begin
      sym      = symbol_value(req_char_code);
      is_dot   = req_char_code == CHAR_DOT;
      active   = seg_ff < SEG_SIGNATURE;
      sym_ok   = active && !is_dot && !sym[6];
      p_clamp  = (pend_ff > 3'd6) ? 3'd6 : pend_ff;
      combined = {acc_ff, sym[5:0]};
      np_raw   = {1'b0, p_clamp} + 4'd6;
      emit     = sym_ok && (np_raw >= 4'd8);
      np       = (np_raw >= 4'd8) ? 3'(np_raw - 4'd8) : np_raw[2:0];
      mask     = (12'd1 << np) - 12'd1;
      dec_byte = 8'(combined >> np);

      seg_next = (active && is_dot) ? seg_ff + 2'd1 : seg_ff;
      case (seg_next)
         SEG_HEADER:  status = STATUS_NO_DOT1;
         SEG_PAYLOAD: status = STATUS_NO_DOT2;
         default:     status = STATUS_OK;
      endcase

      seg_in  = seg_ff;
      pend_in = pend_ff;
      acc_in  = acc_ff;
      if (req_last_char) begin
         seg_in  = SEG_HEADER;
         pend_in = 3'd0;
         acc_in  = 6'd0;
      end else if (active && is_dot) begin
         seg_in  = seg_next;
         pend_in = 3'd0;
         acc_in  = 6'd0;
      end else if (sym_ok) begin
         pend_in = np;
         acc_in  = 6'(combined & mask);
      end

      res_data.item_kind   = KIND_DATA;
      res_data.segment_tag = seg_ff[0];
      res_data.data_byte   = dec_byte;
      res_data.status_code = STATUS_OK;
      res_data.end_mark    = 1'b0;

      res_stat.item_kind   = KIND_STATUS;
      res_stat.segment_tag = 1'b0;
      res_stat.data_byte   = 8'd0;
      res_stat.status_code = status;
      res_stat.end_mark    = 1'b1;

      res0   = emit ? res_data : res_stat;
      res1   = res_stat;
      push_n = 2'({1'b0, emit} + {1'b0, req_last_char});
      if (!req_take) begin
         push_n = 2'd0;
      end

      count_in = count_ff + {1'b0, push_n} - {2'b0, rsp_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff    <= SEG_HEADER;
         pend_ff   <= 3'd0;
         acc_ff    <= 6'd0;
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (req_take) begin
            seg_ff  <= seg_in;
            pend_ff <= pend_in;
            acc_ff  <= acc_in;
         end
         wr_ptr_ff <= wr_ptr_ff + push_n;
         if (rsp_take) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_in;
      end
   end

   // result queue, no reset needed
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= res1;
      end
   end

   assign rsp_valid       = count_ff != 3'd0;
   assign rsp_item_kind   = queue_ff[rd_ptr_ff].item_kind;
   assign rsp_segment_tag = queue_ff[rd_ptr_ff].segment_tag;
   assign rsp_data_byte   = queue_ff[rd_ptr_ff].data_byte;
   assign rsp_status_code = queue_ff[rd_ptr_ff].status_code;
   assign rsp_end_mark    = queue_ff[rd_ptr_ff].end_mark;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue count out of range");

   a_room_on_take: assert property (@(posedge clock) disable iff (reset)
      req_take |-> count_ff <= 3'd2)
      else $error("character taken without room for two results");

   a_end_is_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_mark) |-> rsp_item_kind == KIND_STATUS)
      else $error("end mark on a data result");

   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_last_char) |=> (seg_ff == SEG_HEADER && pend_ff == 3'd0))
      else $error("state not cleared after last character");

endmodule
